[hw/rtl/gaussian_pyramid_downsample_macros.svh]
// assertion macros for the gaussian pyramid downsampler
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef GAUSSIAN_PYRAMID_DOWNSAMPLE_MACROS_SVH
`define GAUSSIAN_PYRAMID_DOWNSAMPLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpd assertion failed");
`define GPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpd assertion failed");
`else
`define GPD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/gpd_pkg.sv]
// constants, types and tap decode for the gaussian pyramid downsampler
// no dependencies
package gpd_pkg;

   localparam int TAPS        = 5;
   localparam int COEF_W      = 5;
   localparam int PIX_W       = 8;
   localparam int VSUM_W      = 12;
   localparam int FW_REG_W    = 12;
   localparam int FH_REG_W    = 13;
   localparam int ROW_W       = 12;
   localparam int MAX_HEIGHT  = 4096;
   localparam int REG_INDEX_W = 1;

   localparam logic [REG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [REG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [COEF_W-1:0] TAP_WEIGHT [TAPS] = '{5'd1, 5'd4, 5'd6, 5'd4, 5'd1};

   // weight per delay: entry j is the summed weight of taps j samples back
   typedef logic [TAPS-1:0][COEF_W-1:0] coef_type;
   typedef logic [3:0][COEF_W-1:0]      bank_coef_type;

   // short_base: last position with even size, taps run one further ahead
   function automatic coef_type delay_coefs(input logic short_base,
                                            input logic [2:0] pos_sat);
      coef_type   coefs;
      logic [2:0] base;
      logic [2:0] dly;
      coefs = '0;
      for (int k = 0; k < TAPS; k++) begin
         if (short_base) begin
            base = (k <= 3) ? 3'(3 - k) : 3'd0;
         end else begin
            base = 3'(4 - k);
         end
         dly = (base < pos_sat) ? base : pos_sat;
         coefs[dly] = coefs[dly] + TAP_WEIGHT[k];
      end
      return coefs;
   endfunction

endpackage

[hw/rtl/gaussian_pyramid_downsample.sv]
// gaussian pyramid reduce: 5-tap binomial blur and 2x decimation of a pixel stream
// depends on gpd_pkg and gaussian_pyramid_downsample_macros.svh
//
// Takes one 8-bit pixel per clock (its sustained rate) in raster order unless
// rsp_tready stalls it, and returns the half-size image (floor(W/2) by floor(H/2))
// blurred by [1 4 6 4 1]/16 in both directions with replicated borders, each
// result the floor of the weighted sum over 256. The pixel that completes a
// result (the pixel at min(2x+2,W-1), min(2y+2,H-1)) has its line-store read
// registered in stage a, its vertical sum in stage b and the horizontal sum in
// the output register. Four line banks of MAX_WIDTH bytes each are read and one
// written at the current column on every pixel. No clearing pass after reset.
// The user must write frame size registers while idle; it is not enforced here.
`include "gaussian_pyramid_downsample_macros.svh"

module gaussian_pyramid_downsample
   import gpd_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] in_pixel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] out_pixel
   output logic                   rsp_tlast,   // frame_done
   input  logic                   csr_we,
   input  logic [REG_INDEX_W-1:0] csr_addr,
   input  logic [FH_REG_W-1:0]    csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int SW = (CW + 1 > FW_REG_W) ? CW + 1 : FW_REG_W;
   localparam int HW = FH_REG_W;

   logic [FW_REG_W-1:0] frame_width_ff;
   logic [FH_REG_W-1:0] frame_height_ff;
   logic [CW-1:0]       col_ff;
   logic [ROW_W-1:0]    row_ff;

   logic [SW-1:0] w_sat, fw_ext, col_ext, col_plus;
   logic [HW-1:0] h_sat, row_ext, row_plus;
   logic          c_last, c_mid, r_last, r_mid, r_emit, c_emit;
   logic [2:0]    c_pos_sat, r_pos_sat;
   coef_type      vcoef, hcoef;
   bank_coef_type bcoef;
   logic [1:0]    bank_sel;

   logic accept, a_move, b_move, a_ready, b_ready, c_ready;

   // stage a: pixel and line-store read
   logic                a_valid_ff;
   logic [PIX_W-1:0]    a_pixel_ff;
   logic [COEF_W-1:0]   a_pcoef_ff;
   bank_coef_type       a_bcoef_ff;
   coef_type            a_hcoef_ff;
   logic                a_emit_ff, a_done_ff, a_row_emit_ff;
   logic [PIX_W-1:0]    line_rd [4];
   logic [13:0]         vacc;
   logic [VSUM_W-1:0]   vs;

   // stage b: vertical sum window
   logic                b_valid_ff, b_emit_ff, b_done_ff;
   coef_type            b_hcoef_ff;
   logic [VSUM_W-1:0]   hist_ff [TAPS];
   logic [18:0]         hacc;

   // stage c: result register
   logic              rsp_valid_ff, rsp_last_ff;
   logic [PIX_W-1:0]  rsp_pixel_ff;

   // frame size saturation and position decode
   always_comb begin
      fw_ext  = SW'(frame_width_ff);
      if (fw_ext < SW'(2)) begin
         w_sat = SW'(2);
      end else if (fw_ext > SW'(MAX_WIDTH)) begin
         w_sat = SW'(MAX_WIDTH);
      end else begin
         w_sat = fw_ext;
      end
      if (frame_height_ff < HW'(2)) begin
         h_sat = HW'(2);
      end else if (frame_height_ff > HW'(MAX_HEIGHT)) begin
         h_sat = HW'(MAX_HEIGHT);
      end else begin
         h_sat = frame_height_ff;
      end
      col_ext  = SW'(col_ff);
      col_plus = col_ext + SW'(1);
      row_ext  = HW'(row_ff);
      row_plus = row_ext + HW'(1);

      c_last = (col_ext == w_sat - SW'(1));
      c_mid  = !col_ff[0] && (col_ext >= SW'(2)) && (col_ext < w_sat - SW'(1));
      r_last = (row_ext == h_sat - HW'(1));
      r_mid  = !row_ff[0] && (row_ext >= HW'(2)) && (row_ext < h_sat - HW'(1));
      c_emit = c_last || c_mid;
      r_emit = r_last || r_mid;

      c_pos_sat = (col_ext >= SW'(4)) ? 3'd4 : col_ff[2:0];
      r_pos_sat = (row_ext >= HW'(4)) ? 3'd4 : row_ff[2:0];

      hcoef = delay_coefs(c_last && !w_sat[0], c_pos_sat);
      vcoef = delay_coefs(r_last && !h_sat[0], r_pos_sat);
      if (!r_emit) begin
         vcoef = '0;
      end

      // rows one to four back live in bank (row - delay) mod 4
      bcoef = '0;
      for (int j = 1; j < TAPS; j++) begin
         bank_sel        = row_ff[1:0] - 2'(j);
         bcoef[bank_sel] = bcoef[bank_sel] + vcoef[j];
      end
   end

   // handshake
   assign c_ready    = !rsp_valid_ff || rsp_tready;
   assign b_move     = b_valid_ff && (!b_emit_ff || c_ready);
   assign b_ready    = !b_valid_ff || b_move;
   assign a_move     = a_valid_ff && b_ready;
   assign a_ready    = !a_valid_ff || a_move;
   assign req_tready = a_ready;
   assign accept     = req_tvalid && a_ready;

   // line store banks
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [PIX_W-1:0] bank_mem [MAX_WIDTH];
      logic [PIX_W-1:0] bank_rd_ff;
      always_ff @(posedge clock) begin
         if (accept) begin
            bank_rd_ff <= bank_mem[col_ff];
            if (row_ff[1:0] == 2'(b)) begin
               bank_mem[col_ff] <= req_tdata;
            end
         end
      end
      assign line_rd[b] = bank_rd_ff;
   end

   // vertical sum, taps of zero weight may point at unwritten rows
   always_comb begin
      vacc = 14'(a_pcoef_ff) * 14'(a_pixel_ff);
      for (int b = 0; b < 4; b++) begin
         if (a_bcoef_ff[b] != '0) begin
            vacc = vacc + 14'(a_bcoef_ff[b]) * 14'(line_rd[b]);
         end
      end
      vs = vacc[VSUM_W-1:0];
   end

   // horizontal sum, hist_ff[TAPS-1] is the newest vertical sum
   always_comb begin
      hacc = '0;
      for (int j = 0; j < TAPS; j++) begin
         if (b_hcoef_ff[j] != '0) begin
            hacc = hacc + 19'(b_hcoef_ff[j]) * 19'(hist_ff[TAPS-1-j]);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_REG_W'(640);
         frame_height_ff <= FH_REG_W'(480);
         col_ff          <= '0;
         row_ff          <= '0;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_FRAME_WIDTH: begin
                  frame_width_ff <= csr_wdata[FW_REG_W-1:0];
               end
               REG_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (accept) begin
            if (col_plus >= w_sat) begin
               col_ff <= '0;
               row_ff <= (row_plus >= h_sat) ? '0 : row_plus[ROW_W-1:0];
            end else begin
               col_ff <= col_plus[CW-1:0];
            end
         end
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (a_move) begin
            a_valid_ff <= 1'b0;
         end
         if (a_move) begin
            b_valid_ff <= 1'b1;
         end else if (b_move) begin
            b_valid_ff <= 1'b0;
         end
         if (b_move && b_emit_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         a_pixel_ff    <= req_tdata;
         a_pcoef_ff    <= vcoef[0];
         a_bcoef_ff    <= bcoef;
         a_hcoef_ff    <= hcoef;
         a_row_emit_ff <= r_emit;
         a_emit_ff     <= r_emit && c_emit;
         a_done_ff     <= r_last && c_last;
      end
      if (a_move) begin
         b_hcoef_ff <= a_hcoef_ff;
         b_emit_ff  <= a_emit_ff;
         b_done_ff  <= a_done_ff;
         for (int j = 0; j < TAPS - 1; j++) begin
            hist_ff[j] <= hist_ff[j+1];
         end
         hist_ff[TAPS-1] <= vs;
      end
      if (b_move && b_emit_ff) begin
         rsp_pixel_ff <= hacc[15:8];
         rsp_last_ff  <= b_done_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;

   `GPD_ASSERT_NEXT(a_accept_fills_stage, clock, reset, accept, a_valid_ff)
   `GPD_ASSERT_IMPLY(a_vsum_in_range, clock, reset, a_valid_ff, vacc <= 14'd4080)
   `GPD_ASSERT_IMPLY(a_vsum_zero_off_row, clock, reset, a_valid_ff && !a_row_emit_ff,
                     vacc == 14'd0)
   `GPD_ASSERT_IMPLY(a_done_only_on_result, clock, reset, b_valid_ff && b_done_ff,
                     b_emit_ff)

endmodule
